@@ design/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the integer literal scanner
// Holds the character classes, the queue entry layout, the number base and
// C type codes, and the sizes of the accumulator and the decoupling queue.
// ----------------------------------------------------------------------------
package ils_pkg;

   // Widths of the C types being modeled.
   localparam int INT_BITS  = 32;
   localparam int LONG_BITS = 64;

   // Width of the value field on the result channel.
   localparam int VALUE_BITS = 64;

   // The accumulator times sixteen plus a digit needs four more bits.
   localparam int ACC_EXT_BITS = LONG_BITS + 4;

   // Queue between the classifier and the evaluator.
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Characters of interest.
   localparam logic [7:0] CHAR_ZERO    = "0";
   localparam logic [7:0] CHAR_ONE     = "1";
   localparam logic [7:0] CHAR_NINE    = "9";
   localparam logic [7:0] CHAR_LOWER_A = "a";
   localparam logic [7:0] CHAR_LOWER_F = "f";
   localparam logic [7:0] CHAR_UPPER_A = "A";
   localparam logic [7:0] CHAR_UPPER_F = "F";
   localparam logic [7:0] CHAR_LOWER_X = "x";
   localparam logic [7:0] CHAR_UPPER_X = "X";
   localparam logic [7:0] CHAR_LOWER_U = "u";
   localparam logic [7:0] CHAR_UPPER_U = "U";
   localparam logic [7:0] CHAR_LOWER_L = "l";
   localparam logic [7:0] CHAR_UPPER_L = "L";

   // Largest digit of each radix.
   localparam logic [3:0] OCT_DIGIT_MAX = 4'd7;
   localparam logic [3:0] DEC_DIGIT_MAX = 4'd9;

   typedef enum logic [2:0] {
      CLS_DIGIT,      // 0-9, a-f or A-F
      CLS_HEX_MARK,   // x or X
      CLS_UNSIGNED,   // u or U
      CLS_LONG,       // l or L
      CLS_OTHER
   } char_class_type;

   typedef enum logic [1:0] {
      BASE_NONE,
      BASE_DEC,
      BASE_OCT,
      BASE_HEX
   } number_base_type;

   typedef enum logic [1:0] {
      TYPE_INT,
      TYPE_UINT,
      TYPE_LONG,
      TYPE_ULONG
   } const_type_type;

   // Suffix flags.
   localparam logic [1:0] SUFFIX_U = 2'b01;
   localparam logic [1:0] SUFFIX_L = 2'b10;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     digit;
      logic           last;
   } ils_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ils_queue_status_type;

endpackage

@@ design/ils_queue.sv @@
// ----------------------------------------------------------------------------
// ils_queue: short FIFO of classified characters
// Register-based queue that decouples the classifier from the evaluator.
// ----------------------------------------------------------------------------
module ils_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  ils_pkg::ils_entry_type        push_entry,
   input  logic                         pop,
   output ils_pkg::ils_entry_type        head_entry,
   output ils_pkg::ils_queue_status_type status
);
   import ils_pkg::*;

   ils_entry_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0]  count_ff, count_in;

   function automatic logic [QUEUE_PTR_BITS-1:0] next_ptr(
      input logic [QUEUE_PTR_BITS-1:0] ptr
   );
      if (ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + QUEUE_PTR_BITS'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

@@ design/ils_front.sv @@
// ----------------------------------------------------------------------------
// ils_front: character classifier and input side of the queue
// Sorts each incoming character into a class with its digit value and
// queues it for the evaluator.
// ----------------------------------------------------------------------------
module ils_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_is_last,
   input  logic                         pop,
   output ils_pkg::ils_entry_type        head_entry,
   output ils_pkg::ils_queue_status_type status
);
   import ils_pkg::*;

   ils_entry_type entry;
   logic          push;

   always_comb begin
      entry.last  = req_is_last;
      entry.digit = '0;
      entry.cls   = CLS_OTHER;
      if (req_char_code inside {[CHAR_ZERO:CHAR_NINE]}) begin
         entry.cls   = CLS_DIGIT;
         entry.digit = req_char_code[3:0];
      end else if (req_char_code inside {[CHAR_LOWER_A:CHAR_LOWER_F]}) begin
         entry.cls   = CLS_DIGIT;
         entry.digit = 4'(req_char_code - CHAR_LOWER_A + 8'd10);
      end else if (req_char_code inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         entry.cls   = CLS_DIGIT;
         entry.digit = 4'(req_char_code - CHAR_UPPER_A + 8'd10);
      end else if (req_char_code inside {CHAR_LOWER_X, CHAR_UPPER_X}) begin
         entry.cls = CLS_HEX_MARK;
      end else if (req_char_code inside {CHAR_LOWER_U, CHAR_UPPER_U}) begin
         entry.cls = CLS_UNSIGNED;
      end else if (req_char_code inside {CHAR_LOWER_L, CHAR_UPPER_L}) begin
         entry.cls = CLS_LONG;
      end
   end

   assign req_stall = status.full;
   assign push      = req_valid && !status.full;

   ils_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

endmodule

@@ design/ils_back.sv @@
// ----------------------------------------------------------------------------
// ils_back: token evaluator and result register
// Tracks base, suffix and value of a token one queued character per cycle
// (a last one held while a response waits) and registers the result on it.
// ----------------------------------------------------------------------------
module ils_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ils_pkg::ils_entry_type        head_entry,
   input  ils_pkg::ils_queue_status_type status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_valid_constant,
   output logic [1:0]                   rsp_const_type,
   output logic [63:0]                  rsp_const_value
);
   import ils_pkg::*;

   logic [1:0]            position_ff, position_in;
   number_base_type       base_ff, base_in;
   logic [LONG_BITS-1:0]  acc_ff, acc_in;
   logic                  failed_ff, failed_in;
   logic [1:0]            suffix_ff, suffix_in;
   logic                  digit_seen_ff, digit_seen_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  valid_constant_ff, valid_constant_in;
   const_type_type        const_type_ff, const_type_in;
   logic [VALUE_BITS-1:0] const_value_ff, const_value_in;

   number_base_type         base_eff;
   logic                    base_ok;
   logic [ACC_EXT_BITS-1:0] acc_ext, scaled, total;
   logic                    digit_ok;
   logic [1:0]              suffix_bit;
   logic                    out_free;
   logic                    finish;
   const_type_type          token_type;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !status.empty && (!head_entry.last || out_free);
   assign finish   = pop && head_entry.last;

   // Base the digit is read in; a first digit decides between octal and
   // decimal.
   always_comb begin
      base_eff = base_ff;
      base_ok  = 1'b1;
      if (base_ff == BASE_NONE) begin
         if (head_entry.cls == CLS_DIGIT && head_entry.digit == 4'd0) begin
            base_eff = BASE_OCT;
         end else if (head_entry.cls == CLS_DIGIT &&
                      head_entry.digit <= DEC_DIGIT_MAX) begin
            base_eff = BASE_DEC;
         end else begin
            base_ok = 1'b0;
         end
      end
   end

   // Multiply by the radix with shifts and add the digit.
   always_comb begin
      acc_ext = ACC_EXT_BITS'(acc_ff);
      case (base_eff)
         BASE_HEX: begin
            scaled   = acc_ext << 4;
            digit_ok = 1'b1;
         end
         BASE_OCT: begin
            scaled   = acc_ext << 3;
            digit_ok = head_entry.digit <= OCT_DIGIT_MAX;
         end
         default: begin
            scaled   = (acc_ext << 3) + (acc_ext << 1);
            digit_ok = head_entry.digit <= DEC_DIGIT_MAX;
         end
      endcase
      digit_ok = digit_ok && head_entry.cls == CLS_DIGIT;
      total    = scaled + ACC_EXT_BITS'(head_entry.digit);
   end

   assign suffix_bit = (head_entry.cls == CLS_UNSIGNED) ? SUFFIX_U : SUFFIX_L;

   always_comb begin
      position_in   = position_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      failed_in     = failed_ff;
      suffix_in     = suffix_ff;
      digit_seen_in = digit_seen_ff;

      if (pop) begin
         if (position_ff != 2'd3) begin
            position_in = position_ff + 2'd1;
         end
         if (!failed_ff) begin
            if (position_ff == 2'd1 && base_ff == BASE_OCT &&
                head_entry.cls == CLS_HEX_MARK) begin
               base_in       = BASE_HEX;
               digit_seen_in = 1'b0;
            end else if (head_entry.cls == CLS_UNSIGNED ||
                         head_entry.cls == CLS_LONG) begin
               if (!digit_seen_ff || (suffix_ff & suffix_bit) != 2'b00) begin
                  failed_in = 1'b1;
               end else begin
                  suffix_in = suffix_ff | suffix_bit;
               end
            end else if (suffix_ff != 2'b00 || !base_ok || !digit_ok ||
                         total[ACC_EXT_BITS-1:LONG_BITS] != '0) begin
               failed_in = 1'b1;
            end else begin
               base_in       = base_eff;
               acc_in        = total[LONG_BITS-1:0];
               digit_seen_in = 1'b1;
            end
         end
      end
   end

   // C type from the final value, base and suffix.
   always_comb begin
      logic fits_int, fits_uint, fits_long;
      fits_int  = (acc_in >> (INT_BITS - 1)) == '0;
      fits_uint = (acc_in >> INT_BITS) == '0;
      fits_long = (acc_in >> (LONG_BITS - 1)) == '0;
      case (suffix_in)
         2'b00: begin
            if (fits_int) begin
               token_type = TYPE_INT;
            end else if ((base_in == BASE_OCT || base_in == BASE_HEX) && fits_uint) begin
               token_type = TYPE_UINT;
            end else if (fits_long) begin
               token_type = TYPE_LONG;
            end else begin
               token_type = TYPE_ULONG;
            end
         end
         SUFFIX_U: token_type = fits_uint ? TYPE_UINT : TYPE_ULONG;
         SUFFIX_L: token_type = fits_long ? TYPE_LONG : TYPE_ULONG;
         default:  token_type = TYPE_ULONG;
      endcase
   end

   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      valid_constant_in = valid_constant_ff;
      const_type_in     = const_type_ff;
      const_value_in    = const_value_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         if (!failed_in && digit_seen_in) begin
            valid_constant_in = 1'b1;
            const_type_in     = token_type;
            const_value_in    = VALUE_BITS'(acc_in);
         end else begin
            valid_constant_in = 1'b0;
            const_type_in     = TYPE_INT;
            const_value_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         position_ff   <= '0;
         base_ff       <= BASE_NONE;
         acc_ff        <= '0;
         failed_ff     <= 1'b0;
         suffix_ff     <= '0;
         digit_seen_ff <= 1'b0;
      end else begin
         position_ff   <= position_in;
         base_ff       <= base_in;
         acc_ff        <= acc_in;
         failed_ff     <= failed_in;
         suffix_ff     <= suffix_in;
         digit_seen_ff <= digit_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      valid_constant_ff <= valid_constant_in;
      const_type_ff     <= const_type_in;
      const_value_ff    <= const_value_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_constant = valid_constant_ff;
   assign rsp_const_type     = const_type_ff;
   assign rsp_const_value    = const_value_ff;

endmodule

@@ design/integer_literal_scanner_unit.sv @@
// ----------------------------------------------------------------------------
// integer_literal_scanner_unit: C89 integer constant scanner
// Reads a token one character per beat and reports, on its last character,
// whether it is a valid integer constant, its C type and its value.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one token character per beat, first to last,
//   with req_is_last set on the final character. Tokens follow each other
//   with no gap. The response channel gives one beat per token, issued for
//   the last character: rsp_valid_constant, rsp_const_type (int, unsigned
//   int, long, unsigned long) and rsp_const_value (zero when invalid).
//   A character accepted into the queue is evaluated at its head, and the
//   response register takes the result of a last character for rsp_valid.
//   The classifier and the evaluator each handle one character per cycle, so
//   the block sustains one request beat every cycle while no response waits
//   on the receiver; the evaluator step (multiply by the radix with shifts,
//   add, overflow test) sets that. A four-entry queue sits between the two.
//   While the receiver stalls, the evaluator keeps consuming characters up to
//   the next last one; with it and three more queued, req_stall rises.
//   The synchronous reset empties the queue, drops any pending response and
//   clears the token state; no initialization pass follows it.
// ----------------------------------------------------------------------------
module integer_literal_scanner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_constant,
   output logic [1:0]  rsp_const_type,
   output logic [63:0] rsp_const_value
);
   import ils_pkg::*;

   // Classified characters waiting for the evaluator.
   ils_entry_type        head_entry;
   ils_queue_status_type queue_status;
   logic                 pop;

   // The front end classifies each character (digit and its value, hex
   // marker, suffix letter or anything else) and queues it.
   ils_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .pop           (pop),
      .head_entry    (head_entry),
      .status        (queue_status)
   );

   // The back end runs the token state and owns the response register. It
   // holds back a last character only while a response is still waiting.
   ils_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_entry         (head_entry),
      .status             (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_valid_constant (rsp_valid_constant),
      .rsp_const_type     (rsp_const_type),
      .rsp_const_value    (rsp_const_value)
   );

   // The queue cannot be full and empty at once.
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue reports full and empty together");

   // A character taken in leaves the queue non-empty at the next edge.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !reset) |=> !queue_status.empty)
      else $error("accepted character did not reach the queue");

   // The evaluator never pulls from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("pop from an empty queue");

   // A rejected token reports type int and value zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_constant) |->
         (rsp_const_type == TYPE_INT && rsp_const_value == '0))
      else $error("invalid token with nonzero type or value");

endmodule
